/* hw/rtl/tsac_pkg.sv */
// tsac_pkg: shared types and constants of the two-sensor actuator controller
// used by tsac_decode, tsac_drive and two_sensor_actuator_controller_core
`timescale 1ns / 1ps
`default_nettype none

package tsac_pkg;

  localparam int unsigned PinWordBitsDef = 32;
  localparam int unsigned PIN_IDX_W      = 6;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 8;

  localparam logic [PIN_IDX_W-1:0] NO_PIN = PIN_IDX_W'(32);

  // position codes
  localparam logic [1:0] LOC_MOVING = 2'd0;
  localparam logic [1:0] LOC_RESET  = 2'd1;
  localparam logic [1:0] LOC_ACTION = 2'd2;

  // latched message codes
  localparam logic [2:0] MSG_NONE      = 3'd0;
  localparam logic [2:0] MSG_ILLEGAL   = 3'd1;
  localparam logic [2:0] MSG_AT_RESET  = 3'd2;
  localparam logic [2:0] MSG_AT_ACTION = 3'd3;
  localparam logic [2:0] MSG_TIMEOUT   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_SENSOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_SENSOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_DRIVE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_DRIVE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_ENABLE    = 3'd5;

  // reset values
  localparam logic [7:0]  TICK_PERIOD_RST = 8'd16;
  localparam logic [15:0] LIMIT_RST       = 16'd5000;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_GOTO  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // sensor decode result
  typedef struct packed {
    logic [1:0] pos;
    logic       illegal;
  } decode_t;

endpackage

`default_nettype wire

/* hw/rtl/tsac_decode.sv */
// tsac_decode: picks the two sensor bits from the sensor word and decodes position
// depends on tsac_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsac_decode #(
  parameter int unsigned PIN_WORD_BITS = tsac_pkg::PinWordBitsDef
) (
  input  wire logic [PIN_WORD_BITS-1:0]       sensor_word_i,
  input  wire logic [tsac_pkg::PIN_IDX_W-1:0] reset_pin_i,
  input  wire logic [tsac_pkg::PIN_IDX_W-1:0] action_pin_i,
  output tsac_pkg::decode_t                   dec_o
);
  import tsac_pkg::*;

  logic r_bit;
  logic a_bit;

  // pins at or above the word width read as zero
  always_comb begin
    r_bit = 1'b0;
    a_bit = 1'b0;
    for (int i = 0; i < PIN_WORD_BITS; i++) begin
      if (reset_pin_i == PIN_IDX_W'(i)) begin
        r_bit = sensor_word_i[i];
      end
      if (action_pin_i == PIN_IDX_W'(i)) begin
        a_bit = sensor_word_i[i];
      end
    end
  end

  always_comb begin
    dec_o.pos     = LOC_MOVING;
    dec_o.illegal = 1'b0;
    if (reset_pin_i == NO_PIN) begin
      dec_o.illegal = 1'b1;
    end else if (action_pin_i == NO_PIN) begin
      dec_o.pos = r_bit ? LOC_ACTION : LOC_RESET;
    end else if (!r_bit && a_bit) begin
      dec_o.pos = LOC_RESET;
    end else if (r_bit && !a_bit) begin
      dec_o.pos = LOC_ACTION;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tsac_drive.sv */
// tsac_drive: sets or clears the two valve bits in the drive word
// depends on tsac_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsac_drive #(
  parameter int unsigned PIN_WORD_BITS = tsac_pkg::PinWordBitsDef
) (
  input  wire logic [PIN_WORD_BITS-1:0]       drive_i,
  input  wire logic [tsac_pkg::PIN_IDX_W-1:0] reset_pin_i,
  input  wire logic [tsac_pkg::PIN_IDX_W-1:0] action_pin_i,
  input  wire logic                           apply_i,
  input  wire logic                           to_action_i,
  output logic      [PIN_WORD_BITS-1:0]       drive_o
);
  import tsac_pkg::*;

  always_comb begin
    drive_o = drive_i;
    for (int i = 0; i < PIN_WORD_BITS; i++) begin
      if (apply_i && reset_pin_i != NO_PIN && reset_pin_i == PIN_IDX_W'(i)) begin
        drive_o[i] = to_action_i;
      end
      if (apply_i && action_pin_i != NO_PIN && action_pin_i == PIN_IDX_W'(i)) begin
        drive_o[i] = !to_action_i;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/two_sensor_actuator_controller_core.sv */
// two_sensor_actuator_controller_core: top level of the pneumatic cylinder controller
// depends on tsac_pkg, tsac_decode, tsac_drive
//
// usage:
//   input channel in_valid_i/in_ready_o carries one transaction per item: an action
//   (tick, goto, clear message), the sensor word, the drive word to modify, a goal
//   position and a timeout in ms. the output channel out_valid_o/out_ready_i returns
//   exactly one result per item: updated drive word, position, latched message and
//   the pending flag.
//   an accepted item sits in an input register; once the result register is free, the
//   decode, drive update, 16x8 tick multiply and timeout compare run in one pass and
//   load the result register together with the controller state. the result is
//   registered, and one item is taken per cycle when the receiver keeps up.
//   when the receiver stalls, the result register holds, the input register fills
//   and in_ready_o drops until the result is taken; nothing is lost or repeated.
//   reset clears both valid flags, sets the configuration to its defaults (no pins,
//   16 ms tick, messages disabled) and the state to moving, target reset, count 0,
//   limit 5000 ms, no message. configuration is written through cfg_we_i while idle.
`timescale 1ns / 1ps
`default_nettype none

module two_sensor_actuator_controller_core #(
  parameter int unsigned PIN_WORD_BITS = tsac_pkg::PinWordBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [tsac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tsac_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      action_i,
  input  wire logic [PIN_WORD_BITS-1:0]        sensor_word_i,
  input  wire logic [PIN_WORD_BITS-1:0]        drive_word_in_i,
  input  wire logic [1:0]                      goal_position_i,
  input  wire logic [15:0]                     limit_ms_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [PIN_WORD_BITS-1:0]        drive_word_out_o,
  output logic      [1:0]                      position_now_o,
  output logic      [2:0]                      event_code_o,
  output logic                                 event_pending_o
);
  import tsac_pkg::*;

  // configuration registers
  logic [PIN_IDX_W-1:0] rs_pin_q, as_pin_q, rd_pin_q, ad_pin_q;
  logic [7:0]           period_q;
  logic                 msg_en_q;

  // controller state
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  target_q, target_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] limit_q, limit_d;
  logic [2:0]  msg_q, msg_d;

  // input register
  logic                     s1_valid_q;
  action_e                  s1_action_q;
  logic [PIN_WORD_BITS-1:0] s1_sensor_q;
  logic [PIN_WORD_BITS-1:0] s1_drive_q;
  logic [1:0]               s1_goal_q;
  logic [15:0]              s1_limit_q;

  // result register
  logic                     out_valid_q;
  logic [PIN_WORD_BITS-1:0] res_drive_q, res_drive_d;
  logic                     res_pend_d;

  logic    in_fire;
  logic    s1_fire;
  decode_t dec;
  logic [PIN_WORD_BITS-1:0] drive_new;
  logic        apply_drive;
  logic [15:0] cnt_inc;
  logic [23:0] prod;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  tsac_decode #(
    .PIN_WORD_BITS(PIN_WORD_BITS)
  ) u_decode (
    .sensor_word_i(s1_sensor_q),
    .reset_pin_i  (rs_pin_q),
    .action_pin_i (as_pin_q),
    .dec_o        (dec)
  );

  // drive is set towards the target while this tick's decoded position differs from it
  assign apply_drive = (dec.pos != target_q);

  tsac_drive #(
    .PIN_WORD_BITS(PIN_WORD_BITS)
  ) u_drive (
    .drive_i     (s1_drive_q),
    .reset_pin_i (rd_pin_q),
    .action_pin_i(ad_pin_q),
    .apply_i     (apply_drive),
    .to_action_i (target_q == LOC_ACTION),
    .drive_o     (drive_new)
  );

  assign cnt_inc = cnt_q + 16'd1;
  assign prod    = {8'd0, cnt_inc} * {16'd0, period_q};

  always_comb begin
    pos_d       = pos_q;
    target_d    = target_q;
    cnt_d       = cnt_q;
    limit_d     = limit_q;
    msg_d       = msg_q;
    res_drive_d = s1_drive_q;
    case (s1_action_q)
      ACT_TICK: begin
        if (dec.illegal) begin
          msg_d = MSG_ILLEGAL;
        end
        if (dec.pos != pos_q) begin
          if (dec.pos == LOC_RESET) begin
            msg_d = MSG_AT_RESET;
          end else if (dec.pos == LOC_ACTION) begin
            msg_d = MSG_AT_ACTION;
          end
        end
        pos_d       = dec.pos;
        res_drive_d = drive_new;
        cnt_d       = cnt_inc;
        if (prod >= {8'd0, limit_q}) begin
          msg_d = MSG_TIMEOUT;
          cnt_d = '0;
        end
      end
      ACT_GOTO: begin
        target_d = s1_goal_q;
        cnt_d    = '0;
        limit_d  = s1_limit_q;
      end
      ACT_CLEAR: begin
        msg_d = MSG_NONE;
      end
      default: begin
      end
    endcase
    res_pend_d = msg_en_q && (msg_d != MSG_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_pin_q <= NO_PIN;
      as_pin_q <= NO_PIN;
      rd_pin_q <= NO_PIN;
      ad_pin_q <= NO_PIN;
      period_q <= TICK_PERIOD_RST;
      msg_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RESET_SENSOR:  rs_pin_q <= cfg_wdata_i[PIN_IDX_W-1:0];
        CFG_ACTION_SENSOR: as_pin_q <= cfg_wdata_i[PIN_IDX_W-1:0];
        CFG_RESET_DRIVE:   rd_pin_q <= cfg_wdata_i[PIN_IDX_W-1:0];
        CFG_ACTION_DRIVE:  ad_pin_q <= cfg_wdata_i[PIN_IDX_W-1:0];
        CFG_TICK_PERIOD:   period_q <= cfg_wdata_i;
        CFG_MSG_ENABLE:    msg_en_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= LOC_MOVING;
      target_q <= LOC_RESET;
      cnt_q    <= '0;
      limit_q  <= LIMIT_RST;
      msg_q    <= MSG_NONE;
    end else if (s1_fire) begin
      pos_q    <= pos_d;
      target_q <= target_d;
      cnt_q    <= cnt_d;
      limit_q  <= limit_d;
      msg_q    <= msg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= action_e'(action_i);
      s1_sensor_q <= sensor_word_i;
      s1_drive_q  <= drive_word_in_i;
      s1_goal_q   <= goal_position_i;
      s1_limit_q  <= limit_ms_i;
    end
    if (s1_fire) begin
      res_drive_q     <= res_drive_d;
      position_now_o  <= pos_d;
      event_code_o    <= msg_d;
      event_pending_o <= res_pend_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_word_out_o = res_drive_q;

  // a reported pending flag always comes with a real message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(event_pending_o && event_code_o == MSG_NONE))
    else $error("pending flag without a message");

  // the input side only stalls when both registers are full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without backpressure");

  // decoded position never takes the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd3)
    else $error("position register holds an unused code");

  // a goto restarts the timeout count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_action_q == ACT_GOTO) |=> (cnt_q == 16'd0))
    else $error("tick count not cleared by goto");

endmodule

`default_nettype wire

/* sim/two_sensor_actuator_controller_core_tb.sv */
// two_sensor_actuator_controller_core_tb: self-checking bench for the cylinder controller core
// drives directed and random transactions, predicts each status word in-bench (or takes the typed one) and compares
// depends on tsac_pkg and two_sensor_actuator_controller_core
`timescale 1ns / 1ps

module two_sensor_actuator_controller_core_tb;
  import tsac_pkg::*;

  localparam int PW = PinWordBitsDef;
  localparam int N_DIR = 36;

  // goal code that no decoded position matches
  localparam logic [1:0] GOAL_NEVER = 2'd3;
  // config indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [31:0] drive;
    logic [1:0]  pos;
    logic [2:0]  code;
    logic        pend;
  } cyl_status_t;

  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    action_e               act;
    logic [31:0]           sensor;
    logic [31:0]           drive;
    logic [1:0]            goal;
    logic [15:0]           limit;
    bit                    known;
    cyl_status_t           want;
  } step_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            action_i;
  logic [PW-1:0]         sensor_word_i;
  logic [PW-1:0]         drive_word_in_i;
  logic [1:0]            goal_position_i;
  logic [15:0]           limit_ms_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PW-1:0]         drive_word_out_o;
  logic [1:0]            position_now_o;
  logic [2:0]            event_code_o;
  logic                  event_pending_o;

  two_sensor_actuator_controller_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .sensor_word_i   (sensor_word_i),
    .drive_word_in_i (drive_word_in_i),
    .goal_position_i (goal_position_i),
    .limit_ms_i      (limit_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_word_out_o(drive_word_out_o),
    .position_now_o  (position_now_o),
    .event_code_o    (event_code_o),
    .event_pending_o (event_pending_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of configuration and controller state
  logic [5:0]  pin_rsens, pin_asens, pin_rdrv, pin_adrv;
  logic [7:0]  tick_ms;
  logic        msg_en;
  logic [1:0]  cyl_pos, cyl_goal;
  logic [15:0] cyl_ticks, cyl_limit;
  logic [2:0]  cyl_msg;

  cyl_status_t status_due_q[$];
  int          fail_cnt = 0;
  bit          tx_idle_on, rx_idle_on;
  int          rx_wait = 0;
  int          long_hold = 0;

  function automatic void cylinder_reset();
    pin_rsens = NO_PIN;
    pin_asens = NO_PIN;
    pin_rdrv  = NO_PIN;
    pin_adrv  = NO_PIN;
    tick_ms   = TICK_PERIOD_RST;
    msg_en    = 1'b0;
    cyl_pos   = LOC_MOVING;
    cyl_goal  = LOC_RESET;
    cyl_ticks = '0;
    cyl_limit = LIMIT_RST;
    cyl_msg   = MSG_NONE;
  endfunction

  function automatic void cfg_note(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_RESET_SENSOR:  pin_rsens = data[5:0];
      CFG_ACTION_SENSOR: pin_asens = data[5:0];
      CFG_RESET_DRIVE:   pin_rdrv  = data[5:0];
      CFG_ACTION_DRIVE:  pin_adrv  = data[5:0];
      CFG_TICK_PERIOD:   tick_ms   = data;
      CFG_MSG_ENABLE:    msg_en    = data[0];
      default: ;
    endcase
  endfunction

  // pins past the word read low and are never driven
  function automatic logic sensor_at(logic [31:0] word, logic [5:0] pin);
    if (pin >= PW) return 1'b0;
    return word[pin];
  endfunction

  function automatic logic [31:0] set_drive(logic [31:0] word, logic [5:0] pin, logic level);
    if (pin < PW) word[pin] = level;
    return word;
  endfunction

  function automatic cyl_status_t cylinder_step(action_e act, logic [31:0] sens,
                                                logic [31:0] drv, logic [1:0] goal,
                                                logic [15:0] lim);
    logic [1:0]  pos;
    logic        r, a, to_act;
    logic [23:0] scaled;
    cyl_status_t st;
    case (act)
      ACT_TICK: begin
        pos = LOC_MOVING;
        r = sensor_at(sens, pin_rsens);
        a = sensor_at(sens, pin_asens);
        if (pin_rsens == NO_PIN) begin
          cyl_msg = MSG_ILLEGAL;
        end else if (pin_asens == NO_PIN) begin
          pos = r ? LOC_ACTION : LOC_RESET;
        end else if (!r && a) begin
          pos = LOC_RESET;
        end else if (r && !a) begin
          pos = LOC_ACTION;
        end
        if (cyl_pos != pos) begin
          if (pos == LOC_RESET) cyl_msg = MSG_AT_RESET;
          else if (pos == LOC_ACTION) cyl_msg = MSG_AT_ACTION;
          cyl_pos = pos;
        end
        if (cyl_pos != cyl_goal) begin
          to_act = (cyl_goal == LOC_ACTION);
          drv = set_drive(drv, pin_rdrv, to_act);
          drv = set_drive(drv, pin_adrv, !to_act);
        end
        cyl_ticks = cyl_ticks + 16'd1;
        scaled = {8'd0, cyl_ticks} * {16'd0, tick_ms};
        if (scaled >= {8'd0, cyl_limit}) begin
          cyl_msg   = MSG_TIMEOUT;
          cyl_ticks = '0;
        end
      end
      ACT_GOTO: begin
        cyl_goal  = goal;
        cyl_ticks = '0;
        cyl_limit = lim;
      end
      ACT_CLEAR: cyl_msg = MSG_NONE;
      default: ;
    endcase
    st.drive = drv;
    st.pos   = cyl_pos;
    st.code  = cyl_msg;
    st.pend  = msg_en && (cyl_msg != MSG_NONE);
    return st;
  endfunction

  // directed part: expected status typed in where it is obvious, else predicted
  step_row_t dir_steps [N_DIR] = '{
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'h0000_0000, 32'hFFFF_FFFF, LOC_MOVING, 16'd0,
      1'b1, '{32'hFFFF_FFFF, LOC_MOVING, MSG_ILLEGAL, 1'b0}},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_CLEAR, 32'h0000_0000, 32'h1234_5678, LOC_MOVING, 16'd0,
      1'b1, '{32'h1234_5678, LOC_MOVING, MSG_NONE, 1'b0}},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_NOP, 32'hFFFF_FFFF, 32'h0000_0000, GOAL_NEVER, 16'hFFFF,
      1'b1, '{32'h0000_0000, LOC_MOVING, MSG_NONE, 1'b0}},
    '{1'b1, CFG_MSG_ENABLE, 8'd1, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b1, CFG_RESET_SENSOR, 8'd0, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b1, CFG_RESET_DRIVE, 8'd31, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b1, CFG_ACTION_DRIVE, 8'd0, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'hFFFF_FFFE, 32'h0000_0000, LOC_MOVING, 16'd0,
      1'b1, '{32'h0000_0000, LOC_RESET, MSG_AT_RESET, 1'b1}},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'h0000_0001, 32'hFFFF_FFFF, LOC_MOVING, 16'd0,
      1'b1, '{32'h7FFF_FFFF, LOC_ACTION, MSG_AT_ACTION, 1'b1}},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_GOTO, 32'h0000_0000, 32'h0F0F_0F0F, LOC_ACTION, 16'd0,
      1'b1, '{32'h0F0F_0F0F, LOC_ACTION, MSG_AT_ACTION, 1'b1}},
    // zero limit times out on the first tick
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'h0000_0001, 32'h0000_0000, LOC_MOVING, 16'd0,
      1'b1, '{32'h0000_0000, LOC_ACTION, MSG_TIMEOUT, 1'b1}},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_CLEAR, 32'h0000_0000, 32'hFFFF_0000, LOC_MOVING, 16'd0,
      1'b1, '{32'hFFFF_0000, LOC_ACTION, MSG_NONE, 1'b0}},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_GOTO, 32'h0000_0000, 32'h0000_0000, GOAL_NEVER, 16'hFFFF,
      1'b1, '{32'h0000_0000, LOC_ACTION, MSG_NONE, 1'b0}},
    // unreachable goal keeps driving towards reset
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'hFFFF_FFFE, 32'h0000_0000, LOC_MOVING, 16'd0,
      1'b1, '{32'h0000_0001, LOC_RESET, MSG_AT_RESET, 1'b1}},
    '{1'b1, CFG_ACTION_SENSOR, 8'd31, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b1, CFG_TICK_PERIOD, 8'd255, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b1, CFG_RESET_SENSOR, 8'd5, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_GOTO, 32'h0000_0000, 32'h0000_0000, LOC_RESET, 16'd255,
      1'b1, '{32'h0000_0000, LOC_RESET, MSG_AT_RESET, 1'b1}},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'h8000_0000, 32'hA5A5_A5A5, LOC_MOVING, 16'd0,
      1'b1, '{32'hA5A5_A5A5, LOC_RESET, MSG_TIMEOUT, 1'b1}},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'h0000_0020, 32'hFFFF_FFFF, LOC_MOVING, 16'd0,
      1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'h8000_0020, 32'h0000_0000, LOC_MOVING, 16'd0,
      1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'h0000_0000, 32'hFFFF_FFFF, LOC_MOVING, 16'd0,
      1'b0, '0},
    // sensor and drive pins beyond the word
    '{1'b1, CFG_ACTION_SENSOR, 8'hFF, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b1, CFG_RESET_SENSOR, 8'd40, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b1, CFG_RESET_DRIVE, 8'd33, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b1, CFG_ACTION_DRIVE, 8'd63, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b1, CFG_MSG_ENABLE, 8'd0, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b1, CFG_TICK_PERIOD, 8'd1, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'hFFFF_FFFF, 32'h5555_5555, LOC_MOVING, 16'd0,
      1'b0, '0},
    '{1'b1, CFG_ACTION_SENSOR, 8'd32, ACT_NOP, 32'h0, 32'h0, LOC_MOVING, 16'd0, 1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'hFFFF_FFFF, 32'hAAAA_AAAA, LOC_MOVING, 16'd0,
      1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_GOTO, 32'h0000_0000, 32'h0000_0000, LOC_MOVING, 16'd3,
      1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'h0000_0000, 32'h0000_0001, LOC_MOVING, 16'd0,
      1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'hFFFF_FFFF, 32'h8000_0000, LOC_MOVING, 16'd0,
      1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_TICK, 32'h1234_5678, 32'hFFFF_FFFF, LOC_MOVING, 16'd0,
      1'b0, '0},
    '{1'b0, CFG_RESET_SENSOR, 8'd0, ACT_NOP, 32'h0000_0000, 32'h3C3C_3C3C, LOC_MOVING, 16'd0,
      1'b0, '0}
  };

  task automatic flag(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  task automatic offer(action_e act, logic [31:0] sens, logic [31:0] drv, logic [1:0] goal,
                       logic [15:0] lim, bit known, cyl_status_t typed);
    int          gap;
    cyl_status_t st;
    gap = tx_idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    sensor_word_i   <= sens;
    drive_word_in_i <= drv;
    goal_position_i <= goal;
    limit_ms_i      <= lim;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    st = cylinder_step(act, sens, drv, goal, lim);
    status_due_q.push_back(known ? typed : st);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    cfg_note(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // waits until every status has returned and the block is idle
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (status_due_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_pin();
    case ($urandom_range(0, 9))
      6: return 8'(NO_PIN);
      7: return 8'd63;
      8: return 8'($urandom_range(0, 255));
      9: return $urandom_range(0, 1) ? 8'd31 : 8'd0;
      default: return 8'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic random_config();
    logic [7:0] period;
    case ($urandom_range(0, 7))
      0: period = 8'd1;
      1: period = 8'd255;
      2: period = 8'd0;
      default: period = 8'($urandom_range(1, 255));
    endcase
    cfg_write(CFG_RESET_SENSOR, pick_pin());
    cfg_write(CFG_ACTION_SENSOR, ($urandom_range(0, 2) == 0) ? 8'(NO_PIN) : pick_pin());
    cfg_write(CFG_RESET_DRIVE, pick_pin());
    cfg_write(CFG_ACTION_DRIVE, pick_pin());
    cfg_write(CFG_TICK_PERIOD, period);
    cfg_write(CFG_MSG_ENABLE, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0)
      cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom));
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'(tick_ms * $urandom_range(1, 12));
    endcase
  endfunction

  // random word with the configured sensor bits set for the wanted position
  function automatic logic [31:0] sensor_for(logic [1:0] pos);
    logic [31:0] w;
    logic        r, a;
    w = $urandom;
    case (pos)
      LOC_RESET:  begin r = 1'b0; a = 1'b1; end
      LOC_ACTION: begin r = 1'b1; a = 1'b0; end
      default: begin
        r = 1'($urandom_range(0, 1));
        a = r;
      end
    endcase
    if (pin_rsens < PW) w[pin_rsens] = r;
    if (pin_asens < PW) w[pin_asens] = a;
    return w;
  endfunction

  // mostly goto followed by ticks that travel and settle, with noise in between
  task automatic random_phase(int n_items);
    int         sent, k, settle;
    logic [1:0] goal, rest;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        offer(action_e'($urandom_range(0, 3)), $urandom, $urandom, 2'($urandom),
              16'($urandom), 1'b0, '0);
        sent++;
      end else begin
        goal = 2'($urandom);
        rest = (goal == LOC_RESET || goal == LOC_ACTION) ? goal : 2'($urandom_range(0, 2));
        offer(ACT_GOTO, $urandom, $urandom, goal, pick_limit(), 1'b0, '0);
        k = $urandom_range(2, 12);
        settle = $urandom_range(0, k);
        for (int j = 0; j < k; j++)
          offer(ACT_TICK, sensor_for(j < settle ? LOC_MOVING : rest), $urandom,
                2'($urandom), 16'($urandom), 1'b0, '0);
        sent += k + 1;
        if ($urandom_range(0, 2) == 0) begin
          offer(ACT_CLEAR, $urandom, $urandom, 2'($urandom), 16'($urandom), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // receiver ready, with per-transaction stalls and the occasional long hold
  initial begin : rx_side
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold > 0) begin
        out_ready_i <= 1'b0;
        long_hold--;
      end else if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : status_check
    cyl_status_t due;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (status_due_q.size() == 0) begin
        $display("%0t: status with nothing outstanding, drive %h", $time, drive_word_out_o);
        fail_cnt++;
      end else begin
        due = status_due_q.pop_front();
        flag("drive_word_out", due.drive, drive_word_out_o);
        flag("position_now", 32'(due.pos), 32'(position_now_o));
        flag("event_code", 32'(due.code), 32'(event_code_o));
        flag("event_pending", 32'(due.pend), 32'(event_pending_o));
      end
      rx_wait = rx_idle_on ? $urandom_range(0, 17) : 0;
    end
  end

  initial begin : stimulus
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_RESET_SENSOR;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    action_i        = ACT_NOP;
    sensor_word_i   = '0;
    drive_word_in_i = '0;
    goal_position_i = LOC_MOVING;
    limit_ms_i      = '0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    cylinder_reset();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_cfg) begin
        wait_drain();
        cfg_write(dir_steps[i].cfg_idx, dir_steps[i].cfg_data);
      end else begin
        offer(dir_steps[i].act, dir_steps[i].sensor, dir_steps[i].drive, dir_steps[i].goal,
              dir_steps[i].limit, dir_steps[i].known, dir_steps[i].want);
      end
    end

    for (int ph = 0; ph < 18; ph++) begin
      wait_drain();
      random_config();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (ph == 5) begin
        // receiver holds off while the sender streams, so the core backs up
        tx_idle_on = 1'b0;
        @(posedge clk_i);
        long_hold = 150;
        @(negedge clk_i);
      end
      random_phase(50);
    end

    // zero tick period holds off the timeout until the period is raised again
    wait_drain();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    cfg_write(CFG_RESET_SENSOR, 8'd0);
    cfg_write(CFG_ACTION_SENSOR, 8'(NO_PIN));
    cfg_write(CFG_RESET_DRIVE, 8'd3);
    cfg_write(CFG_ACTION_DRIVE, 8'd4);
    cfg_write(CFG_TICK_PERIOD, 8'd0);
    cfg_write(CFG_MSG_ENABLE, 8'd1);
    offer(ACT_GOTO, $urandom, $urandom, LOC_ACTION, 16'd20, 1'b0, '0);
    repeat (40)
      offer(ACT_TICK, $urandom, $urandom, 2'($urandom), 16'($urandom), 1'b0, '0);
    wait_drain();
    cfg_write(CFG_TICK_PERIOD, 8'd1);
    repeat (20)
      offer(ACT_TICK, $urandom, $urandom, 2'($urandom), 16'($urandom), 1'b0, '0);

    wait_drain();
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
